// ===== hdl/srwm_pkg.sv =====
// ----------------------------------------------------------------------------
// srwm_pkg: shared definitions for the short read window matcher
// Types, reset values, register indexes and the read character lookup.
// ----------------------------------------------------------------------------
package srwm_pkg;

   localparam int READ_MAX_DEF      = 16;
   localparam int POSITION_BITS_DEF = 32;
   localparam int CHAR_W            = 8;
   localparam int LEN_W             = 5;
   localparam int REG_W             = 64;
   localparam int START_W           = 32;
   localparam int READ_HW_MAX       = 16;

   localparam logic [LEN_W-1:0] LEN_RESET      = 5'd3;
   localparam logic [REG_W-1:0] CHARS_LO_RESET = 64'h0000_0000_0047_4154;
   localparam logic [REG_W-1:0] CHARS_HI_RESET = 64'h0;

   // register indexes on the csr port
   localparam logic [1:0] CSR_READ_LENGTH = 2'd0;
   localparam logic [1:0] CSR_CHARS_LOW   = 2'd1;
   localparam logic [1:0] CSR_CHARS_HIGH  = 2'd2;

   // per-cycle control into every cell of the window chain
   typedef struct packed {
      logic shift;   // a word is accepted: advance the chain
      logic clear;   // end of reference: drop the window after the compare
   } srwm_cell_ctl_type;

   // read character j (0..15) from the two packed registers
   function automatic logic [CHAR_W-1:0] read_char_at(input logic [REG_W-1:0] lo,
                                                      input logic [REG_W-1:0] hi,
                                                      input logic [3:0]       j);
      logic [CHAR_W-1:0] c;
      begin
         if (j[3]) begin
            c = hi[{j[2:0], 3'b000} +: CHAR_W];
         end else begin
            c = lo[{j[2:0], 3'b000} +: CHAR_W];
         end
         return c;
      end
   endfunction

endpackage

// ===== hdl/srwm_cell.sv =====
// ----------------------------------------------------------------------------
// srwm_cell: one window position of the matcher chain
// Holds one reference character, passes it on to the next cell on each
// accepted word and flags a mismatch of the incoming character.
// ----------------------------------------------------------------------------
module srwm_cell
   import srwm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  srwm_cell_ctl_type ctl,
   input  logic [CHAR_W-1:0] char_prev,   // character from the newer neighbor
   input  logic [CHAR_W-1:0] read_char,   // read character aligned to this cell
   output logic [CHAR_W-1:0] char_out,    // held character, to the older neighbor
   output logic              miss
);

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   // compare the character entering this cell now
   assign miss     = (char_prev != read_char);
   assign char_out = char_ff;

   always_comb begin
      char_in = char_ff;
      if (ctl.shift) begin
         char_in = ctl.clear ? '0 : char_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

endmodule

// ===== hdl/short_read_window_match.sv =====
// ----------------------------------------------------------------------------
// short_read_window_match: window matcher with at most one mismatch
// Streams reference characters through a chain of cells and reports each
// window that matches the configured short read.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while req_tready is high; each window is compared
//   as its last one arrives, and each hit is registered in the output or skid register.
// req_tready drops only while both the output register and the skid register
//   hold results that rsp_ has not taken.
// Reset: synchronous; clears the window, the position count and both result
//   registers, and loads the read "TAG" with length 3.
module short_read_window_match
   import srwm_pkg::*;
#(
   parameter int READ_MAX      = READ_MAX_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // reference characters
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] ref_char
   input  logic               req_tlast,   // end_of_reference
   // match results
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [START_W-1:0] rsp_tdata,   // [31:0] start_position
   output logic               rsp_tuser,   // [0] exact
   // configuration
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [REG_W-1:0]   csr_wdata
);

   // only the first sixteen window positions can ever be compared
   localparam int CELLS = (READ_MAX < READ_HW_MAX) ? READ_MAX : READ_HW_MAX;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(CELLS);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [LEN_W-1:0] read_length_ff;
   logic [REG_W-1:0] chars_lo_ff;
   logic [REG_W-1:0] chars_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_length_ff <= LEN_RESET;
         chars_lo_ff    <= CHARS_LO_RESET;
         chars_hi_ff    <= CHARS_HI_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_READ_LENGTH: read_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_CHARS_LOW:   chars_lo_ff    <= csr_wdata;
            CSR_CHARS_HIGH:  chars_hi_ff    <= csr_wdata;
            default: ;  // writes to unknown indexes are dropped
         endcase
      end
   end

   // Effective length: zero acts as one, anything above the chain saturates.
   logic [LEN_W-1:0] len;
   always_comb begin
      len = read_length_ff;
      if (len == '0) begin
         len = LEN_W'(1);
      end
      if (len > LEN_LIMIT) begin
         len = LEN_LIMIT;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain: cell 0 takes the newest character, cell k compares the
   // character that arrived k words earlier. Cell k lines up with read
   // character len-1-k, so cell len-1 sees the window's first character.
   // ------------------------------------------------------------------
   logic              accept;
   srwm_cell_ctl_type cell_ctl;
   logic [CHAR_W-1:0] chain [CELLS+1];
   logic [CELLS-1:0]  miss;
   logic [CELLS-1:0]  first_sel;
   logic [CELLS-1:0]  later_sel;

   assign accept         = req_tvalid && req_tready;
   assign cell_ctl.shift = accept;
   assign cell_ctl.clear = req_tlast;
   assign chain[0]       = req_tdata;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic [LEN_W-1:0]  read_idx;
      logic [CHAR_W-1:0] read_char;

      assign read_idx     = len - LEN_W'(1) - LEN_W'(k);
      assign read_char    = read_char_at(chars_lo_ff, chars_hi_ff, read_idx[3:0]);
      assign first_sel[k] = (LEN_W'(k) == len - LEN_W'(1));
      assign later_sel[k] = (LEN_W'(k) <  len - LEN_W'(1));

      srwm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .char_prev (chain[k]),
         .read_char (read_char),
         .char_out  (chain[k+1]),
         .miss      (miss[k])
      );
   end

   // chain[CELLS] is the oldest character, which falls off the end unread
   logic [CHAR_W-1:0] oldest_unused;
   assign oldest_unused = chain[CELLS];

   // ------------------------------------------------------------------
   // Position count, saturating; restart after the end of a reference.
   // ------------------------------------------------------------------
   logic [POSITION_BITS-1:0] seen_ff;
   logic [POSITION_BITS-1:0] seen_in;
   logic [POSITION_BITS-1:0] seen_next;

   assign seen_next = (seen_ff != POS_MAX) ? seen_ff + POSITION_BITS'(1) : seen_ff;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         seen_in = req_tlast ? '0 : seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // ------------------------------------------------------------------
   // Window decision for the word being accepted
   // ------------------------------------------------------------------
   logic                           window_full;
   logic                           first_ok;
   logic                           later_ok;
   logic                           hit;
   logic                           hit_exact;
   logic [POSITION_BITS-1:0]       start_pos;
   logic [POSITION_BITS+START_W-1:0] start_wide;
   logic [START_W-1:0]             hit_start;

   assign window_full = (seen_next >= POSITION_BITS'(len));
   assign first_ok    = ~|(miss & first_sel);
   assign later_ok    = $onehot0(miss & later_sel);
   assign hit_exact   = ~|(miss & later_sel);
   assign hit         = accept && window_full && first_ok && later_ok;
   assign start_pos   = seen_next - POSITION_BITS'(len) + POSITION_BITS'(1);
   assign start_wide  = {{START_W{1'b0}}, start_pos};
   assign hit_start   = start_wide[START_W-1:0];

   // ------------------------------------------------------------------
   // Output register with a skid stage behind it
   // ------------------------------------------------------------------
   logic               out_valid_ff;
   logic [START_W-1:0] out_start_ff;
   logic               out_exact_ff;
   logic               skid_valid_ff;
   logic [START_W-1:0] skid_start_ff;
   logic               skid_exact_ff;
   logic               take;
   logic               out_free;

   assign take     = out_valid_ff && rsp_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no word is accepted here; refill the output from the skid
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (hit) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_start_ff <= skid_start_ff;
            out_exact_ff <= skid_exact_ff;
         end
      end else if (hit) begin
         if (out_free) begin
            out_start_ff <= hit_start;
            out_exact_ff <= hit_exact;
         end else begin
            skid_start_ff <= hit_start;
            skid_exact_ff <= hit_exact;
         end
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_start_ff;
   assign rsp_tuser  = out_exact_ff;

endmodule

// ===== hdl/srwm_checker.sv =====
// ----------------------------------------------------------------------------
// srwm_checker: port-level checks for the short read window matcher
// Watches the handshakes and the result buffering seen at the ports.
// ----------------------------------------------------------------------------
module srwm_checker
   import srwm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic [7:0]         req_tdata,
   input logic               req_tlast,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [START_W-1:0] rsp_tdata,
   input logic               rsp_tuser,
   input logic               csr_wr_en,
   input logic [1:0]         csr_index,
   input logic [REG_W-1:0]   csr_wdata
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result pending after reset");

   // input backpressure only while a result waits at the output
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // the skid fills only when a result sat stalled the cycle before
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stall without output stall");

endmodule

bind short_read_window_match srwm_checker u_srwm_checker (.*);

// ===== dv/short_read_window_match_checker.sv =====
// ----------------------------------------------------------------------------
// short_read_window_match_checker: scoreboard for the window matcher
// Tracks the read setup from csr writes, keeps its own copy of the sliding
// window and position count, predicts each match from the accepted reference
// words and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module short_read_window_match_checker
   import srwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [START_W-1:0] rsp_tdata,
   input  logic               rsp_tuser,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [REG_W-1:0]   csr_wdata,
   output int                 mismatch_count,
   output int                 hits_pending,
   output int                 hits_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic               exact;
   } window_hit_type;

   window_hit_type               expected_hits[$];
   logic [LEN_W-1:0]             cfg_length;
   logic [REG_W-1:0]             cfg_lo;
   logic [REG_W-1:0]             cfg_hi;
   logic [CHAR_W-1:0]            recent_chars[READ_MAX_DEF];
   logic [POSITION_BITS_DEF-1:0] ref_count;

   // length 0 compares one character, anything past the window depth saturates
   function automatic int span(input logic [LEN_W-1:0] n);
      int depth;
      depth = (READ_MAX_DEF < READ_HW_MAX) ? READ_MAX_DEF : READ_HW_MAX;
      if (n == 0) return 1;
      if (n > depth) return depth;
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] probe_byte(input int j);
      logic [2*REG_W-1:0] both;
      both = {cfg_hi, cfg_lo};
      return both[8*j +: CHAR_W];
   endfunction

   task automatic consume_char(input logic [CHAR_W-1:0] c, input logic last);
      int             n;
      int             misses;
      window_hit_type hit;
      for (int k = READ_MAX_DEF - 1; k > 0; k--) recent_chars[k] = recent_chars[k-1];
      recent_chars[0] = c;
      if (ref_count != '1) ref_count++;
      n = span(cfg_length);
      // oldest window character sits at n-1; test only complete windows
      if (ref_count >= n && recent_chars[n-1] == probe_byte(0)) begin
         misses = 0;
         for (int j = 1; j < n; j++) begin
            if (recent_chars[n-1-j] != probe_byte(j)) misses++;
         end
         if (misses <= 1) begin
            hit.start = START_W'(ref_count - POSITION_BITS_DEF'(n) + 1);
            hit.exact = (misses == 0);
            expected_hits.push_back(hit);
         end
      end
      if (last) begin
         ref_count = '0;
         foreach (recent_chars[k]) recent_chars[k] = '0;
      end
   endtask

   always @(posedge clock) begin
      window_hit_type want;
      if (reset) begin
         cfg_length = LEN_RESET;
         cfg_lo     = CHARS_LO_RESET;
         cfg_hi     = CHARS_HI_RESET;
         ref_count  = '0;
         foreach (recent_chars[k]) recent_chars[k] = '0;
         expected_hits.delete();
         mismatch_count = 0;
         hits_checked   = 0;
      end else begin
         // results first: a result taken now belongs to an earlier word
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: actual start=%0d exact=%0b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_hits.pop_front();
               hits_checked++;
               if (want.start != rsp_tdata) begin
                  mismatch_count++;
                  $display("%0t: start_position mismatch: expected %0d actual %0d",
                           $time, want.start, rsp_tdata);
               end
               if (want.exact != rsp_tuser) begin
                  mismatch_count++;
                  $display("%0t: exact mismatch at start %0d: expected %0b actual %0b",
                           $time, want.start, want.exact, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) consume_char(req_tdata, req_tlast);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_READ_LENGTH: cfg_length = csr_wdata[LEN_W-1:0];
               CSR_CHARS_LOW:   cfg_lo     = csr_wdata;
               CSR_CHARS_HIGH:  cfg_hi     = csr_wdata;
               default: ;
            endcase
         end
      end
      hits_pending = expected_hits.size();
   end

endmodule

// ===== dv/short_read_window_match_tb.sv =====
// ----------------------------------------------------------------------------
// short_read_window_match_tb: stimulus and verdict for the window matcher
// Streams reference words through the block under a sequence of read setups,
// with random gaps on both channels, one long result stall and a settle
// between setups; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module short_read_window_match_tb;
   import srwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_WORDS   = 40;
   localparam int PHASE_WORDS  = 220;
   localparam int NUM_PHASES   = 9;
   localparam int DRAIN_CYCLES = 4;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [7:0]         req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [START_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [REG_W-1:0]   csr_wdata;

   int mismatch_count;
   int hits_pending;
   int hits_checked;

   // stimulus-side copy of the read, used only to plant matching windows
   logic [LEN_W-1:0] cur_len;
   logic [REG_W-1:0] cur_lo;
   logic [REG_W-1:0] cur_hi;

   int   words_sent;
   int   setups_used;
   int   stall_cycles;
   int   cycle_count;
   logic sender_calm;
   logic rsp_calm;
   logic hold_request;
   logic hold_done;

   short_read_window_match i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   short_read_window_match_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .hits_pending   (hits_pending),
      .hits_checked   (hits_checked)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // count cycles the block pushes back on an offered word
   initial stall_cycles = 0;
   always @(posedge clock) begin
      if (req_tvalid && !req_tready) stall_cycles++;
   end

   // watchdog: end the run if the traffic never drains
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // result side: draw a wait per word, go quiet now and then, and honor the
   // one long hold-off that the stimulus asks for
   initial begin
      int wait_cycles;
      rsp_tready = 1'b0;
      rsp_calm   = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            // hold ready low long enough for the output and skid to fill
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            wait_cycles = rsp_calm ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_cycles) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic int eff_len();
      if (cur_len == 0) return 1;
      if (cur_len > READ_HW_MAX) return READ_HW_MAX;
      return cur_len;
   endfunction

   function automatic logic [7:0] read_byte(input int j);
      logic [2*REG_W-1:0] both;
      both = {cur_hi, cur_lo};
      return both[8*j +: 8];
   endfunction

   // offer one word after a drawn gap; hold it until the block takes it
   task automatic send_word(input logic [7:0] c, input logic last);
      int gap;
      if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) send_word(s[i], last_at_end && i == s.len() - 1);
   endtask

   // drop valid and wait until every predicted match has come back, then
   // give the block time to finish a word that causes no result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (hits_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all three registers on consecutive cycles
   task automatic program_read(input logic [LEN_W-1:0] len, input logic [REG_W-1:0] lo,
                               input logic [REG_W-1:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_READ_LENGTH;
      csr_wdata <= REG_W'(len);
      @(negedge clock);
      csr_index <= CSR_CHARS_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_CHARS_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_len = len;
      cur_lo  = lo;
      cur_hi  = hi;
      setups_used++;
   endtask

   // random traffic: mostly planted copies of the read (exact, one miss,
   // or broken), the rest read characters and raw bytes, with stray ends
   task automatic run_phase(input int count);
      int         sent;
      int         n;
      int         pick;
      int         bad;
      int         bad2;
      logic [7:0] c;
      n    = eff_len();
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            bad  = -1;
            bad2 = -1;
            pick = $urandom_range(0, 99);
            if (pick < 35 && n > 1) begin
               bad = $urandom_range(1, n - 1);
            end else if (pick < 50) begin
               bad  = $urandom_range(0, n - 1);
               bad2 = $urandom_range(0, n - 1);
            end
            for (int j = 0; j < n; j++) begin
               c = read_byte(j);
               if (j == bad || j == bad2) c ^= 8'($urandom_range(1, 255));
               send_word(c, j == n - 1 && $urandom_range(0, 19) == 0);
               sent++;
            end
         end else begin
            if (pick < 55) c = 8'($urandom_range(0, 255));
            else c = read_byte($urandom_range(0, n - 1));
            send_word(c, $urandom_range(0, 29) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      logic [LEN_W-1:0] len;
      logic [REG_W-1:0] lo;
      logic [REG_W-1:0] hi;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_READ_LENGTH;
      csr_wdata    = '0;
      hold_request = 1'b0;
      sender_calm  = 1'b0;
      words_sent   = 0;
      setups_used  = 0;
      cur_len      = LEN_RESET;
      cur_lo       = CHARS_LO_RESET;
      cur_hi       = CHARS_HI_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words against the reset read "TAG", length 3:
      // exact and one-miss hits, a bad first character, byte extremes,
      // an end right after a hit, an end on an incomplete window, restart
      send_text("TAGTAC", 1'b0);
      send_text("CAG", 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_text("TAG", 1'b1);
      send_text("TA", 1'b1);
      send_text("TAG", 1'b0);
      send_text("GTAA", 1'b1);
      settle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         case (ph)
            0: len = 5'd1;
            1: begin
               len = 5'd16;
               lo  = '1;
               hi  = '1;
            end
            2: begin
               len = 5'd0;
               lo  = '0;
               hi  = '0;
            end
            3: len = 5'd31;
            4: len = 5'd17;
            default: len = LEN_W'($urandom_range(2, 15));
         endcase
         program_read(len, lo, hi);
         if (ph == 0) begin
            // length one: every copy of character 0 hits; keep offering
            // while results are held off so the block backs up
            hold_request = 1'b1;
            repeat (HOLD_WORDS) send_word(read_byte(0), 1'b0);
            run_phase(PHASE_WORDS - HOLD_WORDS);
         end else begin
            run_phase(PHASE_WORDS);
         end
         settle();
      end

      $display("summary: %0d reference words over %0d read setups, %0d matches checked",
               words_sent, setups_used + 1, hits_checked);
      $display("summary: lengths 0, 1, 16, 17, 31 and random, %0d input stall cycles",
               stall_cycles);
      if (mismatch_count == 0 && hits_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
